>>> rtl/cfhc_pkg.sv
package cfhc_pkg;

   localparam int STAMP_PORT_WIDTH = 16;
   localparam int FREQ_WIDTH       = 32;
   localparam int CNT_PORT_WIDTH   = 8;
   localparam int CSR_IDX_WIDTH    = 2;
   localparam int STEP_WIDTH       = $clog2(FREQ_WIDTH);

   localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(FREQ_WIDTH - 1);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REF_CLOCK = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HIGH_THR  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LOW_THR   = 2'd2;

   localparam logic [FREQ_WIDTH-1:0] REF_CLOCK_RESET = 32'd22500000;
   localparam logic [FREQ_WIDTH-1:0] HIGH_THR_RESET  = 32'd2000000;
   localparam logic [FREQ_WIDTH-1:0] LOW_THR_RESET   = 32'd1650000;

   typedef struct packed {
      logic                      freq_valid;
      logic [FREQ_WIDTH-1:0]     frequency;
      logic                      high_event;
      logic                      low_event;
      logic [CNT_PORT_WIDTH-1:0] crossing_count;
      logic                      halted;
   } rsp_type;

endpackage

>>> rtl/capture_frequency_hysteresis_counter_unit.sv
// Capture frequency meter with hysteresis crossing counter.
// req_ channel: one timer capture stamp per transfer. Stamps pair up; the
// second stamp of a pair yields frequency = ref_clock_hz / (second - first).
// rsp_ channel: one result per accepted stamp (frequency, high/low events,
// crossing count, halted flag), held in an output register.
// csr_ channel: register writes (0 ref clock, 1 high threshold, 2 low
// threshold); csr_ready is high whenever no division is running.
// A stamp that opens a pair, a halted stamp or an equal pair gets its result
// straight into the output register; a pair-closing stamp waits for the
// bit-serial restoring divider, which retires one quotient bit per cycle.
// Pair-opening stamps are taken one per cycle while rsp_stall does not hold;
// no stamp is taken while a division runs, as the divider handles one item at a time.
// Reset (synchronous) restores default registers, arms the detector, clears
// the count, the pair state and the halt flag, and empties the output.
// While rsp_stall holds, the result waits in the output register and
// req_stall stays high, so no new stamp is taken until it transfers.
module capture_frequency_hysteresis_counter_unit #(
   parameter int STAMP_WIDTH = 16,
   parameter int COUNT_WIDTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [cfhc_pkg::STAMP_PORT_WIDTH-1:0]  req_capture_stamp,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_freq_valid,
   output logic [cfhc_pkg::FREQ_WIDTH-1:0]        rsp_frequency,
   output logic                                   rsp_high_event,
   output logic                                   rsp_low_event,
   output logic [cfhc_pkg::CNT_PORT_WIDTH-1:0]    rsp_crossing_count,
   output logic                                   rsp_halted,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cfhc_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [cfhc_pkg::FREQ_WIDTH-1:0]        csr_wdata
);

   localparam int SW = STAMP_WIDTH;
   localparam int FW = cfhc_pkg::FREQ_WIDTH;
   localparam int CW = COUNT_WIDTH;
   localparam int OW = cfhc_pkg::CNT_PORT_WIDTH;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;

   logic                            state_ff, state_in;
   logic [cfhc_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic [FW-1:0]                   ref_clock_ff, ref_clock_in;
   logic [FW-1:0]                   high_thr_ff, high_thr_in;
   logic [FW-1:0]                   low_thr_ff, low_thr_in;
   logic                            have_first_ff, have_first_in;
   logic [SW-1:0]                   first_stamp_ff, first_stamp_in;
   logic [FW-1:0]                   last_freq_ff, last_freq_in;
   logic                            armed_ff, armed_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic                            halt_ff, halt_in;
   logic [SW-1:0]                   divisor_ff, divisor_in;
   logic [SW-1:0]                   rem_ff, rem_in;
   logic [FW-1:0]                   quo_ff, quo_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   cfhc_pkg::rsp_type               out_ff, out_in;

   logic          accept;
   logic [SW-1:0] stamp;
   logic [SW-1:0] diff;
   logic [SW:0]   trial;
   logic [SW:0]   trial_sub;
   logic          quo_bit;
   logic [SW-1:0] rem_next;
   logic [FW-1:0] quo_next;
   logic          hi_hit;
   logic          armed_mid;
   logic          lo_hit;
   logic [CW-1:0] count_bump;
   logic [CW+OW-1:0] cnt_now_ext;
   logic [CW+OW-1:0] cnt_bump_ext;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE);

   assign stamp = SW'(req_capture_stamp);
   assign diff  = stamp - first_stamp_ff;

   // restoring division, one quotient bit per cycle
   assign trial     = {rem_ff, quo_ff[FW-1]};
   assign trial_sub = trial - {1'b0, divisor_ff};
   assign quo_bit   = (trial >= {1'b0, divisor_ff});
   assign rem_next  = quo_bit ? trial_sub[SW-1:0] : trial[SW-1:0];
   assign quo_next  = {quo_ff[FW-2:0], quo_bit};

   // hysteresis: high check first, then low on the updated arm state
   assign hi_hit     = (quo_next > high_thr_ff) && armed_ff;
   assign armed_mid  = armed_ff && !hi_hit;
   assign lo_hit     = (quo_next < low_thr_ff) && !armed_mid;
   assign count_bump = hi_hit ? count_ff + {{(CW-1){1'b0}}, 1'b1} : count_ff;

   assign cnt_now_ext  = {{OW{1'b0}}, count_ff};
   assign cnt_bump_ext = {{OW{1'b0}}, count_bump};

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      ref_clock_in   = ref_clock_ff;
      high_thr_in    = high_thr_ff;
      low_thr_in     = low_thr_ff;
      have_first_in  = have_first_ff;
      first_stamp_in = first_stamp_ff;
      last_freq_in   = last_freq_ff;
      armed_in       = armed_ff;
      count_in       = count_ff;
      halt_in        = halt_ff;
      divisor_in     = divisor_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_in         = out_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cfhc_pkg::CSR_REF_CLOCK: ref_clock_in = csr_wdata;
            cfhc_pkg::CSR_HIGH_THR:  high_thr_in  = csr_wdata;
            cfhc_pkg::CSR_LOW_THR:   low_thr_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in          = 1'b1;
               out_in.freq_valid     = 1'b0;
               out_in.frequency      = last_freq_ff;
               out_in.high_event     = 1'b0;
               out_in.low_event      = 1'b0;
               out_in.crossing_count = cnt_now_ext[OW-1:0];
               out_in.halted         = halt_ff;
               if (!halt_ff) begin
                  if (!have_first_ff) begin
                     first_stamp_in = stamp;
                     have_first_in  = 1'b1;
                  end else begin
                     have_first_in = 1'b0;
                     if (diff == '0) begin
                        halt_in       = 1'b1;
                        out_in.halted = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b0;
                        divisor_in   = diff;
                        rem_in       = '0;
                        quo_in       = ref_clock_ff;
                        step_in      = cfhc_pkg::STEP_LAST;
                        state_in     = ST_DIV;
                     end
                  end
               end
            end
         end
         ST_DIV: begin
            rem_in  = rem_next;
            quo_in  = quo_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in              = ST_IDLE;
               last_freq_in          = quo_next;
               armed_in              = armed_mid || lo_hit;
               count_in              = count_bump;
               rsp_valid_in          = 1'b1;
               out_in.freq_valid     = 1'b1;
               out_in.frequency      = quo_next;
               out_in.high_event     = hi_hit;
               out_in.low_event      = lo_hit;
               out_in.crossing_count = cnt_bump_ext[OW-1:0];
               out_in.halted         = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ref_clock_ff   <= cfhc_pkg::REF_CLOCK_RESET;
         high_thr_ff    <= cfhc_pkg::HIGH_THR_RESET;
         low_thr_ff     <= cfhc_pkg::LOW_THR_RESET;
         have_first_ff  <= 1'b0;
         first_stamp_ff <= '0;
         last_freq_ff   <= '0;
         armed_ff       <= 1'b1;
         count_ff       <= '0;
         halt_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ref_clock_ff   <= ref_clock_in;
         high_thr_ff    <= high_thr_in;
         low_thr_ff     <= low_thr_in;
         have_first_ff  <= have_first_in;
         first_stamp_ff <= first_stamp_in;
         last_freq_ff   <= last_freq_in;
         armed_ff       <= armed_in;
         count_ff       <= count_in;
         halt_ff        <= halt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      out_ff     <= out_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_freq_valid     = out_ff.freq_valid;
   assign rsp_frequency      = out_ff.frequency;
   assign rsp_high_event     = out_ff.high_event;
   assign rsp_low_event      = out_ff.low_event;
   assign rsp_crossing_count = out_ff.crossing_count;
   assign rsp_halted         = out_ff.halted;

`ifndef NO_ASSERTIONS
   a_div_out_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !rsp_valid_ff)
      else $error("output holds a result while dividing");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   a_event_needs_freq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_ff.high_event || out_ff.low_event)) |-> out_ff.freq_valid)
      else $error("event reported without a new frequency");

   a_halt_blocks_div: assert property (@(posedge clock) disable iff (reset)
      (halt_ff && state_ff == ST_IDLE) |=> (state_ff == ST_IDLE))
      else $error("divider started while halted");
`endif

endmodule

>>> verif/capture_frequency_hysteresis_counter_unit_test.sv
module capture_frequency_hysteresis_counter_unit_test;

   typedef logic [cfhc_pkg::STAMP_PORT_WIDTH-1:0] stamp_type;
   typedef logic [cfhc_pkg::FREQ_WIDTH-1:0]       word_type;
   typedef logic [cfhc_pkg::CSR_IDX_WIDTH-1:0]    index_type;

   localparam index_type CSR_UNUSED = 2'd3;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_ITEMS = 255;
   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE      = 40;

   typedef enum logic {ROW_STAMP, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      index_type         idx;
      word_type          value;
      logic              fixed;
      cfhc_pkg::rsp_type golden;
   } row_type;

   localparam int HALT_ROW = 28;
   localparam int NUM_ROWS = 33;

   localparam row_type PLAN [NUM_ROWS] = '{
      '{ROW_STAMP, '0, 32'h0000, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b0, 8'd0, 1'b0}},
      '{ROW_STAMP, '0, 32'hffff, 1'b0, '0},
      '{ROW_STAMP, '0, 32'hffff, 1'b0, '0},
      // wrap to a span of one: far above the high threshold
      '{ROW_STAMP, '0, 32'h0000, 1'b1, '{1'b1, 32'd22500000, 1'b1, 1'b0, 8'd1, 1'b0}},
      '{ROW_STAMP, '0, 32'h1234, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h123e, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h0100, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h0164, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h8000, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h800b, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h5555, 1'b0, '0},
      '{ROW_STAMP, '0, 32'haaaa, 1'b0, '0},
      // inverted thresholds
      '{ROW_REG, cfhc_pkg::CSR_REF_CLOCK, 32'hffffffff, 1'b0, '0},
      '{ROW_REG, cfhc_pkg::CSR_HIGH_THR, 32'h00000000, 1'b0, '0},
      '{ROW_REG, cfhc_pkg::CSR_LOW_THR, 32'hffffffff, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h7fff, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h8000, 1'b1, '{1'b1, 32'hffffffff, 1'b1, 1'b0, 8'd3, 1'b0}},
      '{ROW_STAMP, '0, 32'h0001, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h0003, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h0000, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h0002, 1'b1, '{1'b1, 32'h7fffffff, 1'b1, 1'b1, 8'd4, 1'b0}},
      // zero reference clock
      '{ROW_REG, cfhc_pkg::CSR_REF_CLOCK, 32'h00000000, 1'b0, '0},
      '{ROW_STAMP, '0, 32'hffff, 1'b0, '0},
      '{ROW_STAMP, '0, 32'hfffe, 1'b1, '{1'b1, 32'd0, 1'b0, 1'b0, 8'd4, 1'b0}},
      '{ROW_REG, CSR_UNUSED, 32'hdeadbeef, 1'b0, '0},
      '{ROW_REG, cfhc_pkg::CSR_REF_CLOCK, cfhc_pkg::REF_CLOCK_RESET, 1'b0, '0},
      '{ROW_REG, cfhc_pkg::CSR_HIGH_THR, cfhc_pkg::HIGH_THR_RESET, 1'b0, '0},
      '{ROW_REG, cfhc_pkg::CSR_LOW_THR, cfhc_pkg::LOW_THR_RESET, 1'b0, '0},
      // equal pair, then everything is ignored
      '{ROW_STAMP, '0, 32'h4321, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h4321, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h0000, 1'b0, '0},
      '{ROW_STAMP, '0, 32'h0001, 1'b0, '0},
      '{ROW_STAMP, '0, 32'hffff, 1'b0, '0}
   };

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   stamp_type                             req_capture_stamp = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic                                  rsp_freq_valid;
   word_type                              rsp_frequency;
   logic                                  rsp_high_event;
   logic                                  rsp_low_event;
   logic [cfhc_pkg::CNT_PORT_WIDTH-1:0]   rsp_crossing_count;
   logic                                  rsp_halted;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   index_type                             csr_index = '0;
   word_type                              csr_wdata = '0;

   capture_frequency_hysteresis_counter_unit uut (.*);

   always #5 clock = ~clock;

   // meter state as seen from outside
   word_type                              ref_hz = cfhc_pkg::REF_CLOCK_RESET;
   word_type                              thr_hi = cfhc_pkg::HIGH_THR_RESET;
   word_type                              thr_lo = cfhc_pkg::LOW_THR_RESET;
   logic                                  pair_open = 1'b0;
   stamp_type                             pair_first = '0;
   word_type                              freq_hold = '0;
   logic                                  armed = 1'b1;
   logic [cfhc_pkg::CNT_PORT_WIDTH-1:0]   crossings = '0;
   logic                                  stuck = 1'b0;

   cfhc_pkg::rsp_type readings_due [$];
   int      errors = 0;
   int      quiet = 0;
   int      stall_left = 0;
   bit      stall_on = 1'b1;
   bit      gaps_on = 1'b0;

   function automatic cfhc_pkg::rsp_type measure(input stamp_type stamp);
      cfhc_pkg::rsp_type r;
      stamp_type         span;
      r = '0;
      if (!stuck) begin
         if (!pair_open) begin
            pair_first = stamp;
            pair_open = 1'b1;
         end else begin
            span = stamp - pair_first;
            pair_open = 1'b0;
            if (span == '0) begin
               stuck = 1'b1;
            end else begin
               freq_hold = ref_hz / {16'd0, span};
               r.freq_valid = 1'b1;
               if (freq_hold > thr_hi && armed) begin
                  r.high_event = 1'b1;
                  crossings = crossings + 1'b1;
                  armed = 1'b0;
               end
               if (freq_hold < thr_lo && !armed) begin
                  r.low_event = 1'b1;
                  armed = 1'b1;
               end
            end
         end
      end
      r.frequency = freq_hold;
      r.crossing_count = crossings;
      r.halted = stuck;
      return r;
   endfunction

   task automatic drain();
      while (readings_due.size() != 0) @(posedge clock);
   endtask

   task automatic feed(input stamp_type stamp, input logic fixed,
                       input cfhc_pkg::rsp_type golden);
      cfhc_pkg::rsp_type due;
      req_valid <= 1'b1;
      req_capture_stamp <= stamp;
      do @(posedge clock); while (req_stall);
      due = measure(stamp);
      readings_due.push_back(fixed ? golden : due);
   endtask

   task automatic write_reg(input index_type index, input word_type data);
      req_valid <= 1'b0;
      drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         cfhc_pkg::CSR_REF_CLOCK: ref_hz = data;
         cfhc_pkg::CSR_HIGH_THR: thr_hi = data;
         cfhc_pkg::CSR_LOW_THR: thr_lo = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic run_row(input row_type row);
      if (row.kind == ROW_REG) begin
         write_reg(row.idx, row.value);
      end else begin
         feed(row.value[cfhc_pkg::STAMP_PORT_WIDTH-1:0], row.fixed, row.golden);
      end
   endtask

   task automatic report(input string field, input word_type want, input word_type got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cfhc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (readings_due.size() == 0) begin
            $display("%0t: unexpected result transfer, actual frequency %0h", $time,
                     rsp_frequency);
            errors++;
         end else begin
            want = readings_due.pop_front();
            report("freq_valid", word_type'(want.freq_valid), word_type'(rsp_freq_valid));
            report("frequency", want.frequency, rsp_frequency);
            report("high_event", word_type'(want.high_event), word_type'(rsp_high_event));
            report("low_event", word_type'(want.low_event), word_type'(rsp_low_event));
            report("crossing_count", word_type'(want.crossing_count),
                   word_type'(rsp_crossing_count));
            report("halted", word_type'(want.halted), word_type'(rsp_halted));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet <= 0;
         end else if (quiet >= QUIET_LIMIT) begin
            $display("[capture_frequency_hysteresis_counter_unit] ERROR");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   initial begin
      int        ph;
      int        n;
      int        d1;
      int        gap;
      int        pick;
      word_type  rc;
      word_type  hi;
      word_type  lo;
      word_type  t;
      stamp_type stamp;
      stamp_type span;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < HALT_ROW; i++) run_row(PLAN[i]);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         stall_on = (ph % 3 != 2);
         gaps_on = (ph % 3 != 1);
         if (ph != 0) begin
            case (ph)
               1: begin
                  rc = 32'd1;
                  hi = 32'd0;
                  lo = 32'd1;
               end
               NUM_PHASES - 1: begin
                  rc = '1;
                  hi = '1;
                  lo = '0;
               end
               default: begin
                  rc = $urandom_range(0, 1) ? $urandom : $urandom_range(1000, 50000000);
                  d1 = $urandom_range(2, 40);
                  hi = rc / d1;
                  lo = rc / (d1 + $urandom_range(1, 30));
                  if ($urandom_range(0, 3) == 0) begin
                     t = hi;
                     hi = lo;
                     lo = t;
                  end
               end
            endcase
            write_reg(cfhc_pkg::CSR_REF_CLOCK, rc);
            write_reg(cfhc_pkg::CSR_HIGH_THR, hi);
            write_reg(cfhc_pkg::CSR_LOW_THR, lo);
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (!pair_open) begin
               stamp = stamp_type'($urandom);
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 60) span = stamp_type'($urandom_range(1, 64));
               else if (pick < 85) span = stamp_type'($urandom_range(1, 2048));
               else span = stamp_type'($urandom_range(1, 65535));
               stamp = pair_first + span;
            end
            feed(stamp, 1'b0, '0);
            if ((ph == 0 && n == 40) || $urandom_range(0, 199) == 0) begin
               req_valid <= 1'b0;
               drain();
            end else if (gaps_on) begin
               pick = $urandom_range(0, 99);
               if (pick < 70) gap = 0;
               else if (pick < 95) gap = $urandom_range(1, 3);
               else gap = $urandom_range(10, 60);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
      end

      stall_on = 1'b1;
      if (pair_open) feed(pair_first + 16'd1, 1'b0, '0);
      for (int i = HALT_ROW; i < NUM_ROWS; i++) run_row(PLAN[i]);

      req_valid <= 1'b0;
      drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("[capture_frequency_hysteresis_counter_unit] OK");
      end else begin
         $display("[capture_frequency_hysteresis_counter_unit] ERROR");
      end
      $finish;
   end

endmodule
